// ===== hdl/ust_pkg.sv =====
// ust_pkg: shared sizes, codes and structs of the unordered set table
// depends on nothing; used by ust_cell and unordered_set_table
`default_nettype none

package ust_pkg;

    // number of cells in the chain, one stored value each
    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // field widths of the ports
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int CAP_W     = 7;
    localparam int CAP_RESET = 64;
    localparam int CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int SCAN_W    = (IDX_W > 0) ? IDX_W : 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUP       = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // search word handed from cell to cell
    typedef struct packed {
        logic [VAL_W-1:0] key;
        logic             hit;
        logic [IDX_W-1:0] slot;
        logic [VAL_W-1:0] last_data;
        logic [VAL_W-1:0] cur_data;
    } t_probe;

    // broadcast write into one cell
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] data;
    } t_wr;

endpackage

`default_nettype wire

// ===== hdl/ust_cell.sv =====
// ust_cell: one slot of the set, compares the passing probe and forwards it
// depends on ust_pkg
`default_nettype none

module ust_cell (
    input  wire logic                      i_clk,
    input  wire logic [ust_pkg::IDX_W-1:0] i_idx,
    input  wire logic [ust_pkg::CNT_W-1:0] i_count,
    input  wire logic [ust_pkg::CNT_W-1:0] i_cursor,
    input  wire ust_pkg::t_wr              i_wr,
    input  wire ust_pkg::t_probe           i_probe,
    output ust_pkg::t_probe                o_probe
);

    logic [ust_pkg::VAL_W-1:0] r_entry;
    ust_pkg::t_probe           r_probe;
    ust_pkg::t_probe           n_probe;
    logic [ust_pkg::CNT_W-1:0] idx_ext;
    logic                      live;

    assign idx_ext = ust_pkg::CNT_W'(i_idx);
    assign live    = idx_ext < i_count;

    always_comb begin
        n_probe = i_probe;
        // first match from slot zero upward wins
        if (!i_probe.hit && live && (r_entry == i_probe.key)) begin
            n_probe.hit  = 1'b1;
            n_probe.slot = i_idx;
        end
        if (idx_ext + ust_pkg::CNT_W'(1) == i_count) begin
            n_probe.last_data = r_entry;
        end
        if (idx_ext == i_cursor) begin
            n_probe.cur_data = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_entry <= i_wr.data;
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ===== hdl/unordered_set_table.sv =====
// unordered_set_table: top level, command control, count and cursor, cell chain
// depends on ust_pkg and ust_cell
`default_nettype none

// Set of up to 64 distinct signed 32-bit values kept unordered in a chain of
// cells. A command is taken when start is high and busy is low. Every command
// (insert, remove, member query, iterator restart, iterator next, clear) goes
// the same way from acceptance to result: a search word walks the 64-cell chain,
// one cell per cycle, collecting the first matching slot, the last stored word
// and the word under the cursor, then the done state decides and writes back. The
// result is shown on the o_ result ports for exactly one cycle with o_valid
// high; it cannot be held off, so capture it in that cycle. busy drops in the
// cycle the result is shown, so the next command may be accepted then.
// capacity is written through i_cfg_we / i_cfg_wdata; the user must write it only
// while the block is idle, the block itself does not enforce it; values above 64 act as 64.

module unordered_set_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ust_pkg::CMD_W-1:0]     i_command,
    input  wire logic signed [ust_pkg::VAL_W-1:0] i_value,
    // capacity register
    input  wire logic                          i_cfg_we,
    input  wire logic [ust_pkg::CAP_W-1:0]     i_cfg_wdata,
    // result channel
    output logic                               o_valid,
    output logic [ust_pkg::STAT_W-1:0]         o_status,
    output logic signed [ust_pkg::VAL_W-1:0]   o_value_out,
    output logic [ust_pkg::POS_W-1:0]          o_position,
    output logic [ust_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_is_empty
);

    // command latch
    logic [ust_pkg::CMD_W-1:0]  r_cmd;
    logic [ust_pkg::VAL_W-1:0]  r_val;

    // architectural state
    logic [ust_pkg::CNT_W-1:0]  r_count,  n_count;
    logic [ust_pkg::CNT_W-1:0]  r_cursor, n_cursor;
    logic [ust_pkg::CAP_W-1:0]  r_capacity;

    // control
    ust_pkg::t_state            r_state, n_state;
    logic [ust_pkg::SCAN_W-1:0] r_scan;
    logic                       accept;
    logic                       scan_last;
    logic                       in_scan;
    logic                       in_done;

    // result registers
    logic                       r_valid;
    logic [ust_pkg::STAT_W-1:0] r_status,  n_status;
    logic [ust_pkg::VAL_W-1:0]  r_vout,    n_vout;
    logic [ust_pkg::POS_W-1:0]  r_pos,     n_pos;
    logic [ust_pkg::COUNT_W-1:0] r_ocount;

    // chain
    ust_pkg::t_probe            head;
    ust_pkg::t_probe            chain [ust_pkg::DEPTH+1];
    ust_pkg::t_probe            tail;
    ust_pkg::t_wr               wr;

    logic                       full;
    logic                       exhausted;

    assign accept    = start && (r_state == ust_pkg::S_IDLE);
    assign scan_last = (r_scan == ust_pkg::SCAN_W'(ust_pkg::DEPTH - 1));

    // ---------------------------------------------------------------
    // state machine: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ust_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = ust_pkg::S_SCAN;
                end
            end
            ust_pkg::S_SCAN: begin
                // the last scan count ends the walk; the tail then holds the finished word
                if (scan_last) begin
                    n_state = ust_pkg::S_DONE;
                end
            end
            ust_pkg::S_DONE: begin
                n_state = ust_pkg::S_IDLE;
            end
            default: begin
                n_state = ust_pkg::S_IDLE;
            end
        endcase
    end

    // state machine: outputs
    always_comb begin
        busy    = 1'b1;
        in_scan = 1'b0;
        in_done = 1'b0;
        unique case (r_state)
            ust_pkg::S_IDLE: busy    = 1'b0;
            ust_pkg::S_SCAN: in_scan = 1'b1;
            ust_pkg::S_DONE: in_done = 1'b1;
            default:         busy    = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ust_pkg::S_IDLE;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_scan <= '0;
            end else if (in_scan) begin
                r_scan <= r_scan + ust_pkg::SCAN_W'(1);
            end
        end
    end

    // command latch, held stable for the whole walk
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= ust_pkg::CAP_W'(ust_pkg::CAP_RESET);
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // cell chain: search word enters at cell 0 and leaves at the tail
    // ---------------------------------------------------------------
    always_comb begin
        head     = '0;
        head.key = r_val;
    end

    assign chain[0] = head;

    for (genvar g = 0; g < ust_pkg::DEPTH; g++) begin : g_cell
        ust_cell u_cell (
            .i_clk    (i_clk),
            .i_idx    (ust_pkg::IDX_W'(g)),
            .i_count  (r_count),
            .i_cursor (r_cursor),
            .i_wr     (wr),
            .i_probe  (chain[g]),
            .o_probe  (chain[g+1])
        );
    end

    assign tail = chain[ust_pkg::DEPTH];

    // full when count reached capacity or the chain itself
    assign full = (ust_pkg::CMP_W'(r_count) >= ust_pkg::CMP_W'(r_capacity))
               || (r_count == ust_pkg::CNT_W'(ust_pkg::DEPTH));
    assign exhausted = (r_cursor >= r_count);

    // ---------------------------------------------------------------
    // decide and write back once the walk is over
    // ---------------------------------------------------------------
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_status = ust_pkg::ST_OK;
        n_vout   = '0;
        n_pos    = '0;
        wr       = '0;
        if (in_done) begin
            case (r_cmd)
                ust_pkg::CMD_INSERT: begin
                    if (full) begin
                        n_status = ust_pkg::ST_FULL;
                    end else if (tail.hit) begin
                        n_status = ust_pkg::ST_DUP;
                        n_pos    = ust_pkg::POS_W'(tail.slot);
                    end else begin
                        // append after the last stored word
                        wr.en    = 1'b1;
                        wr.idx   = ust_pkg::IDX_W'(r_count);
                        wr.data  = r_val;
                        n_pos    = ust_pkg::POS_W'(r_count);
                        n_count  = r_count + ust_pkg::CNT_W'(1);
                    end
                end
                ust_pkg::CMD_REMOVE: begin
                    if (tail.hit) begin
                        // last word moves into the freed slot
                        wr.en    = 1'b1;
                        wr.idx   = tail.slot;
                        wr.data  = tail.last_data;
                        n_count  = r_count - ust_pkg::CNT_W'(1);
                        n_vout   = r_val;
                        n_pos    = ust_pkg::POS_W'(tail.slot);
                    end else begin
                        n_status = ust_pkg::ST_NOT_FOUND;
                    end
                end
                ust_pkg::CMD_QUERY: begin
                    if (tail.hit) begin
                        n_pos    = ust_pkg::POS_W'(tail.slot);
                    end else begin
                        n_status = ust_pkg::ST_NOT_FOUND;
                    end
                end
                ust_pkg::CMD_RESTART: begin
                    n_cursor = '0;
                end
                ust_pkg::CMD_NEXT: begin
                    if (exhausted) begin
                        n_status = ust_pkg::ST_EXHAUSTED;
                    end else begin
                        n_vout   = tail.cur_data;
                        n_pos    = ust_pkg::POS_W'(r_cursor);
                        n_cursor = r_cursor + ust_pkg::CNT_W'(1);
                    end
                end
                ust_pkg::CMD_CLEAR: begin
                    n_count  = '0;
                    n_cursor = '0;
                end
                default: begin
                    // unused codes leave everything as is
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_valid  <= in_done;
        end
    end

    // result word, loaded in the done state and marked valid for one cycle
    always_ff @(posedge i_clk) begin
        if (in_done) begin
            r_status <= n_status;
            r_vout   <= n_vout;
            r_pos    <= n_pos;
            r_ocount <= ust_pkg::COUNT_W'(n_count);
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
    assign o_position  = r_pos;
    assign o_count     = r_ocount;
    assign o_is_empty  = (r_ocount == '0);

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for the unordered set table, with a driver, a monitor and a
// predictor of the set kept in the bench; depends on ust_pkg and unordered_set_table
`timescale 1ns / 100ps

module tb_top;
    import ust_pkg::*;

    // command codes with no operation behind them
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam logic [VAL_W-1:0] V_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] V_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] V_NEG1 = 32'hffff_ffff;

    localparam int WD_LIMIT   = 1500; // cycles with no word moving before giving up
    localparam int TAIL_QUIET = 150;  // last words go out with no idling
    localparam int PRINT_MAX  = 40;

    typedef enum logic [1:0] {
        K_CMD,
        K_CFG,
        K_DRAIN
    } item_kind_t;

    typedef struct {
        item_kind_t       kind;
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] val;
        logic [CAP_W-1:0] cap;
    } work_item_t;

    // one answer word of the table
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VAL_W-1:0]   value;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } answer_t;

    // dut ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [CMD_W-1:0]        i_command = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    i_cfg_we = 1'b0;
    logic [CAP_W-1:0]        i_cfg_wdata = '0;
    logic                    o_valid;
    logic [STAT_W-1:0]       o_status;
    logic signed [VAL_W-1:0] o_value_out;
    logic [POS_W-1:0]        o_position;
    logic [COUNT_W-1:0]      o_count;
    logic                    o_is_empty;

    // stimulus and scoreboard
    work_item_t cmd_queue[$];
    answer_t    answer_q[$];
    int         n_accepted = 0;
    int         n_results = 0;   // written by the monitor with nonblocking updates only
    int         n_errors = 0;

    // bench copy of the set
    logic [VAL_W-1:0] tbl_vals [DEPTH];
    int               tbl_count = 0;
    int               cursor = 0;
    int               cap_model = CAP_RESET;

    // idling control of the driver
    int gap_left = 0;
    bit gap_always = 1'b0;
    int idle_pct = 25;

    // value pool for random words, so inserts, removes and lookups collide
    logic [VAL_W-1:0] value_pool [96];
    int               pool_len = 8;

    unordered_set_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_position  (o_position),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic flag_error(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        if (n_errors < PRINT_MAX) begin
            $display("tb_top: answer %0d %s: got %0h want %0h", n_results, what, got, want);
        end
        n_errors++;
    endtask

    // first slot holding v, linear search from slot 0 like the hardware
    function automatic int find_slot(logic [VAL_W-1:0] v);
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_vals[IDX_W'(i)] == v) return i;
        end
        return -1;
    endfunction

    // applies one command to the bench copy of the set and returns its answer word
    function automatic answer_t predict_answer(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] v);
        answer_t a;
        int      slot;
        int      eff_cap;
        a = '0;
        // capacity above the table size acts as the table size
        eff_cap = (cap_model > DEPTH) ? DEPTH : cap_model;
        slot = find_slot(v);
        case (cmd)
            CMD_INSERT: begin
                // full is checked before already present
                if (tbl_count >= eff_cap) begin
                    a.status = ST_FULL;
                end else if (slot >= 0) begin
                    a.status = ST_DUP;
                    a.position = POS_W'(slot);
                end else begin
                    tbl_vals[IDX_W'(tbl_count)] = v;
                    a.position = POS_W'(tbl_count);
                    tbl_count++;
                end
            end
            CMD_REMOVE: begin
                if (slot >= 0) begin
                    // last entry moves into the freed slot
                    tbl_vals[IDX_W'(slot)] = tbl_vals[IDX_W'(tbl_count - 1)];
                    tbl_count--;
                    a.value = v;
                    a.position = POS_W'(slot);
                end else begin
                    a.status = ST_NOT_FOUND;
                end
            end
            CMD_QUERY: begin
                if (slot >= 0) begin
                    a.position = POS_W'(slot);
                end else begin
                    a.status = ST_NOT_FOUND;
                end
            end
            CMD_RESTART: begin
                cursor = 0;
            end
            CMD_NEXT: begin
                // cursor may sit past the count after removals
                if (cursor >= tbl_count) begin
                    a.status = ST_EXHAUSTED;
                end else begin
                    a.value = tbl_vals[IDX_W'(cursor)];
                    a.position = POS_W'(cursor);
                    cursor++;
                end
            end
            CMD_CLEAR: begin
                tbl_count = 0;
                cursor = 0;
            end
            default: begin
            end
        endcase
        a.count = COUNT_W'(tbl_count);
        a.is_empty = (tbl_count == 0);
        return a;
    endfunction

    // driver: one item out of the queue per free slot, idling in bursts
    always @(posedge i_clk) begin : drive_proc
        work_item_t it;
        logic       nx_start;
        logic       nx_we;
        if (i_rst_n) begin
            nx_start = start;
            nx_we = 1'b0;
            // capacity write lands at this edge
            if (i_cfg_we) begin
                cap_model = int'(i_cfg_wdata);
            end
            // command word taken at this edge
            if (start && !busy) begin
                answer_q.push_back(predict_answer(i_command, i_value));
                n_accepted++;
                nx_start = 1'b0;
                if (n_accepted % 100 == 0) begin
                    case ($urandom_range(0, 2))
                        0: idle_pct = 0;
                        1: idle_pct = 25;
                        default: idle_pct = 70;
                    endcase
                end
                if (cmd_queue.size() > TAIL_QUIET && $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(1, 17);
                    // either counted from acceptance (lands inside the scan) or from ready
                    gap_always = 1'($urandom_range(0, 1));
                end
            end
            if (!nx_start) begin
                if (gap_left > 0) begin
                    if (gap_always || !busy) gap_left--;
                end else if (cmd_queue.size() > 0) begin
                    it = cmd_queue[0];
                    case (it.kind)
                        K_CMD: begin
                            nx_start = 1'b1;
                            i_command <= it.cmd;
                            i_value <= it.val;
                            void'(cmd_queue.pop_front());
                        end
                        K_CFG: begin
                            // only with every answer in and the block idle
                            if (n_accepted == n_results && !busy) begin
                                nx_we = 1'b1;
                                i_cfg_wdata <= it.cap;
                                void'(cmd_queue.pop_front());
                            end
                        end
                        default: begin
                            if (n_accepted == n_results) void'(cmd_queue.pop_front());
                        end
                    endcase
                end
            end
            start <= nx_start;
            i_cfg_we <= nx_we;
        end
    end

    // monitor: every strobed answer against the oldest prediction
    always @(posedge i_clk) begin : answer_check
        answer_t want;
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                flag_error("answer with nothing outstanding", '0, '0);
            end else begin
                want = answer_q.pop_front();
                if (o_status !== want.status) begin
                    flag_error("status", VAL_W'(o_status), VAL_W'(want.status));
                end
                if (o_value_out !== want.value) flag_error("value_out", o_value_out, want.value);
                if (o_position !== want.position) begin
                    flag_error("position", VAL_W'(o_position), VAL_W'(want.position));
                end
                if (o_count !== want.count) begin
                    flag_error("count", VAL_W'(o_count), VAL_W'(want.count));
                end
                if (o_is_empty !== want.is_empty) begin
                    flag_error("is_empty", VAL_W'(o_is_empty), VAL_W'(want.is_empty));
                end
            end
            n_results <= n_results + 1;
        end
    end

    // watchdog on cycles where no word moves
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("tb_top: stalled with %0d answers outstanding", answer_q.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
        work_item_t it;
        it.kind = K_CMD;
        it.cmd = cmd;
        it.val = val;
        it.cap = '0;
        cmd_queue.push_back(it);
    endtask

    // waits for all answers, then writes the capacity
    task automatic push_cap(logic [CAP_W-1:0] cap);
        work_item_t it;
        it.kind = K_DRAIN;
        it.cmd = '0;
        it.val = '0;
        it.cap = '0;
        cmd_queue.push_back(it);
        it.kind = K_CFG;
        it.cap = cap;
        cmd_queue.push_back(it);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72) return value_pool[7'($urandom_range(0, pool_len - 1))];
        if (r < 90) return $urandom;
        case ($urandom_range(0, 3))
            0: return V_MIN;
            1: return V_MAX;
            2: return '0;
            default: return V_NEG1;
        endcase
    endfunction

    // one random phase: capacity, pool size, share of inserts, number of words
    task automatic run_phase(int cap, int plen, int ins_pct, bit fresh_pool, int n_items);
        int r;
        int k;
        int walk;
        push_cap(CAP_W'(cap));
        if (fresh_pool) begin
            pool_len = plen;
            for (int i = 0; i < 96; i++) value_pool[7'(i)] = $urandom;
        end
        k = 0;
        while (k < n_items) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                push_cmd(CMD_INSERT, pick_value());
                k++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    push_cmd(CMD_REMOVE, pick_value());
                    k++;
                end else if (r < 60) begin
                    push_cmd(CMD_QUERY, pick_value());
                    k++;
                end else if (r < 75) begin
                    push_cmd(CMD_NEXT, $urandom);
                    k++;
                end else if (r < 80) begin
                    push_cmd(CMD_RESTART, $urandom);
                    k++;
                end else if (r < 84) begin
                    push_cmd(CMD_CLEAR, $urandom);
                    k++;
                end else if (r < 87) begin
                    push_cmd($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7, $urandom);
                    k++;
                end else if (r < 89) begin
                    // sender holds off until the table has answered everything
                    cmd_queue.push_back('{K_DRAIN, '0, '0, '0});
                end else begin
                    // iterator walk: restart then a run of next words
                    walk = $urandom_range(1, 24);
                    push_cmd(CMD_RESTART, $urandom);
                    for (int j = 0; j < walk; j++) push_cmd(CMD_NEXT, $urandom);
                    k += walk + 1;
                end
            end
        end
    endtask

    initial begin
        // directed: empty table, extremes, duplicates, swap on remove, stale cursor
        push_cmd(CMD_NEXT, V_MAX);
        push_cmd(CMD_REMOVE, '0);
        push_cmd(CMD_QUERY, '0);
        push_cmd(CMD_INSERT, V_MIN);
        push_cmd(CMD_INSERT, V_MAX);
        push_cmd(CMD_INSERT, '0);
        push_cmd(CMD_INSERT, V_NEG1);
        push_cmd(CMD_INSERT, V_MIN);
        push_cmd(CMD_QUERY, V_MAX);
        push_cmd(CMD_RESTART, V_NEG1);
        for (int i = 0; i < 5; i++) push_cmd(CMD_NEXT, '0);
        push_cmd(CMD_REMOVE, V_MIN);
        push_cmd(CMD_NEXT, '0);
        push_cmd(CMD_REMOVE, V_NEG1);
        push_cmd(CMD_SPARE6, V_MIN);
        push_cmd(CMD_SPARE7, 32'h5a5a_a5a5);
        push_cmd(CMD_CLEAR, V_NEG1);
        push_cmd(CMD_NEXT, '0);
        // zero capacity, then full tested before already present
        push_cap(7'd0);
        push_cmd(CMD_INSERT, 32'd5);
        push_cap(7'd2);
        push_cmd(CMD_INSERT, 32'd1);
        push_cmd(CMD_INSERT, 32'd2);
        push_cmd(CMD_INSERT, 32'd3);
        push_cmd(CMD_INSERT, 32'd1);
        // capacity lowered below the count
        push_cap(7'd1);
        push_cmd(CMD_INSERT, 32'd9);
        push_cmd(CMD_CLEAR, '0);

        // random phases over several capacities, fill phases reach the table size
        run_phase(64, 16, 40, 1'b1, 95);
        run_phase(64, 96, 85, 1'b1, 100);
        run_phase(0, 8, 40, 1'b1, 80);
        run_phase(1, 4, 40, 1'b1, 90);
        run_phase(2, 6, 40, 1'b1, 90);
        run_phase(7, 12, 50, 1'b1, 100);
        run_phase(127, 96, 85, 1'b1, 110);
        run_phase(65, 40, 50, 1'b1, 100);
        run_phase(63, 80, 80, 1'b1, 100);
        run_phase(3, 80, 30, 1'b0, 100);
        run_phase($urandom_range(0, 127), 32, 50, 1'b1, 100);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || n_accepted != n_results || start) begin
            @(posedge i_clk);
        end
        // let any stray answer show up
        repeat (80) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
